/* rtl/lsfp_pkg.sv */
// Shared types and constants for the LED stream frame parser.
package lsfp_pkg;

  localparam int MAX_LEDS = 1024;
  localparam int QUEUE_DEPTH = 4;

  // result kinds
  localparam logic [2:0] KIND_LED_WRITE = 3'd0;
  localparam logic [2:0] KIND_SHOWN     = 3'd1;
  localparam logic [2:0] KIND_ACK       = 3'd2;
  localparam logic [2:0] KIND_BLANK     = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // parser position
  localparam logic [2:0] HDR_A      = 3'd0;
  localparam logic [2:0] HDR_D      = 3'd1;
  localparam logic [2:0] HDR_LA     = 3'd2;
  localparam logic [2:0] HDR_CNT_HI = 3'd3;
  localparam logic [2:0] HDR_CNT_LO = 3'd4;
  localparam logic [2:0] HDR_CHK    = 3'd5;
  localparam logic [2:0] HDR_DATA   = 3'd6;

  // position inside an RGB triple
  localparam logic [1:0] BYTE_RED   = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_BLUE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LEDS_PRESENT   = 2'd0;
  localparam logic [1:0] REG_ACK_INTERVAL   = 2'd1;
  localparam logic [1:0] REG_RECV_TIMEOUT   = 2'd2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CHK_SEED   = 8'h55;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       last;
  } res_t;

endpackage

/* rtl/led_stream_frame_parser.sv */
// LED stream frame parser: byte/tick parsing with a small result queue.
//
// One item (serial byte or millisecond tick) is taken per clock while the
// four-entry result queue has room for two results; an item yields up to two
// results, which are registered into the queue and drain at one per cycle
// while out_ready is high. Sustained rate is one item per cycle whenever the
// output side takes one result per cycle and items average at most one result
// each. Configuration writes take effect on the next clock.
module led_stream_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [9:0]  led_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  white,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [10:0] leds_present;
  logic [15:0] ack_interval_ms;
  logic [15:0] receive_timeout_ms;

  logic [2:0]  header_pos, header_pos_next;
  logic [16:0] frame_leds, frame_leds_next;
  logic [7:0]  count_high, count_high_next;
  logic [16:0] led_pos, led_pos_next;
  logic [1:0]  byte_in_led, byte_in_led_next;
  logic [7:0]  red_hold, red_hold_next;
  logic [7:0]  green_hold, green_hold_next;
  logic [15:0] idle_elapsed, idle_elapsed_next;
  logic [15:0] ack_elapsed, ack_elapsed_next;
  logic        started, started_next;

  lsfp_pkg::res_t queue [lsfp_pkg::QUEUE_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic           in_xfer, out_xfer;
  logic [1:0]     n_res;
  lsfp_pkg::res_t res0, res1;
  logic           clear_f;
  logic           blank;
  logic [15:0]    ack_sat, idle_sat;
  logic [10:0]    limit;
  logic [16:0]    led_pos_inc;
  logic [7:0]     min_rg, min_rgb;
  logic [7:0]     chk;

  function automatic logic [7:0] frame_leds_low(input logic [16:0] f);
    logic [16:0] d;
    d = f - 17'd1;
    return d[7:0];
  endfunction

  assign in_ready  = (count <= 3'd2);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign out_xfer  = out_valid && out_ready;

  assign kind      = queue[rd_ptr].kind;
  assign led_index = queue[rd_ptr].led_index;
  assign red       = queue[rd_ptr].red;
  assign green     = queue[rd_ptr].green;
  assign blue      = queue[rd_ptr].blue;
  assign white     = queue[rd_ptr].white;
  assign last      = queue[rd_ptr].last;

  assign ack_sat     = (ack_elapsed == lsfp_pkg::SAT16) ? ack_elapsed : ack_elapsed + 16'd1;
  assign idle_sat    = (idle_elapsed == lsfp_pkg::SAT16) ? idle_elapsed : idle_elapsed + 16'd1;
  assign limit       = (leds_present > 11'(lsfp_pkg::MAX_LEDS)) ?
                       11'(lsfp_pkg::MAX_LEDS) : leds_present;
  assign led_pos_inc = led_pos + 17'd1;
  assign min_rg      = (red_hold < green_hold) ? red_hold : green_hold;
  assign min_rgb     = (rx_byte < min_rg) ? rx_byte : min_rg;
  assign chk         = count_high ^ frame_leds_low(frame_leds) ^ lsfp_pkg::CHK_SEED;

  always_comb begin
    header_pos_next   = header_pos;
    frame_leds_next   = frame_leds;
    count_high_next   = count_high;
    led_pos_next      = led_pos;
    byte_in_led_next  = byte_in_led;
    red_hold_next     = red_hold;
    green_hold_next   = green_hold;
    idle_elapsed_next = idle_elapsed;
    ack_elapsed_next  = ack_elapsed;
    started_next      = started;
    n_res             = 2'd0;
    res0              = '0;
    res1              = '0;
    clear_f           = 1'b0;
    blank             = 1'b0;
    if (in_xfer) begin
      if (!mode) begin
        idle_elapsed_next = '0;
        unique case (header_pos)
          lsfp_pkg::HDR_A: begin
            if (rx_byte == lsfp_pkg::CH_UPPER_A) begin
              header_pos_next = lsfp_pkg::HDR_D;
            end else begin
              clear_f = 1'b1;
              res0.kind = lsfp_pkg::KIND_ERROR;
              n_res = 2'd1;
            end
          end
          lsfp_pkg::HDR_D: begin
            if (rx_byte == lsfp_pkg::CH_LOWER_D) begin
              header_pos_next = lsfp_pkg::HDR_LA;
            end else begin
              clear_f = 1'b1;
              res0.kind = lsfp_pkg::KIND_ERROR;
              n_res = 2'd1;
            end
          end
          lsfp_pkg::HDR_LA: begin
            if (rx_byte == lsfp_pkg::CH_LOWER_A) begin
              header_pos_next = lsfp_pkg::HDR_CNT_HI;
            end else begin
              clear_f = 1'b1;
              res0.kind = lsfp_pkg::KIND_ERROR;
              n_res = 2'd1;
            end
          end
          lsfp_pkg::HDR_CNT_HI: begin
            count_high_next = rx_byte;
            header_pos_next = lsfp_pkg::HDR_CNT_LO;
          end
          lsfp_pkg::HDR_CNT_LO: begin
            frame_leds_next = {1'b0, count_high, rx_byte} + 17'd1;
            header_pos_next = lsfp_pkg::HDR_CHK;
          end
          lsfp_pkg::HDR_CHK: begin
            if (rx_byte == chk) begin
              header_pos_next  = lsfp_pkg::HDR_DATA;
              led_pos_next     = '0;
              byte_in_led_next = lsfp_pkg::BYTE_RED;
            end else begin
              clear_f = 1'b1;
              res0.kind = lsfp_pkg::KIND_ERROR;
              n_res = 2'd1;
            end
          end
          default: begin
            case (byte_in_led)
              lsfp_pkg::BYTE_RED: begin
                red_hold_next    = rx_byte;
                byte_in_led_next = lsfp_pkg::BYTE_GREEN;
              end
              lsfp_pkg::BYTE_GREEN: begin
                green_hold_next  = rx_byte;
                byte_in_led_next = lsfp_pkg::BYTE_BLUE;
              end
              default: begin
                if (led_pos < {6'd0, limit}) begin
                  res0.kind      = lsfp_pkg::KIND_LED_WRITE;
                  res0.led_index = led_pos[9:0];
                  res0.red       = red_hold;
                  res0.green     = green_hold;
                  res0.blue      = rx_byte;
                  res0.white     = min_rgb;
                  n_res          = 2'd1;
                end
                led_pos_next     = led_pos_inc;
                byte_in_led_next = lsfp_pkg::BYTE_RED;
                if (led_pos_inc >= frame_leds) begin
                  clear_f = 1'b1;
                  if (n_res == 2'd0) begin
                    res0.kind = lsfp_pkg::KIND_SHOWN;
                  end else begin
                    res1.kind = lsfp_pkg::KIND_SHOWN;
                  end
                  n_res = n_res + 2'd1;
                end
              end
            endcase
          end
        endcase
      end else begin
        idle_elapsed_next = idle_sat;
        if (ack_sat >= ack_interval_ms) begin
          res0.kind        = lsfp_pkg::KIND_ACK;
          n_res            = 2'd1;
          ack_elapsed_next = '0;
        end else begin
          ack_elapsed_next = ack_sat;
        end
        started_next = 1'b1;
        blank = !started ||
                ((header_pos != lsfp_pkg::HDR_A) && (idle_sat >= receive_timeout_ms));
        if (blank) begin
          clear_f = 1'b1;
          if (n_res == 2'd0) begin
            res0.kind = lsfp_pkg::KIND_BLANK;
          end else begin
            res1.kind = lsfp_pkg::KIND_BLANK;
          end
          n_res = n_res + 2'd1;
        end
      end
    end
    if (clear_f) begin
      header_pos_next  = lsfp_pkg::HDR_A;
      frame_leds_next  = '0;
      count_high_next  = '0;
      led_pos_next     = '0;
      byte_in_led_next = lsfp_pkg::BYTE_RED;
      red_hold_next    = '0;
      green_hold_next  = '0;
    end
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leds_present       <= 11'd1024;
      ack_interval_ms    <= 16'd1000;
      receive_timeout_ms <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfp_pkg::REG_LEDS_PRESENT: leds_present       <= cfg_data[10:0];
        lsfp_pkg::REG_ACK_INTERVAL: ack_interval_ms    <= cfg_data;
        lsfp_pkg::REG_RECV_TIMEOUT: receive_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos   <= lsfp_pkg::HDR_A;
      frame_leds   <= '0;
      count_high   <= '0;
      led_pos      <= '0;
      byte_in_led  <= lsfp_pkg::BYTE_RED;
      red_hold     <= '0;
      green_hold   <= '0;
      idle_elapsed <= '0;
      ack_elapsed  <= lsfp_pkg::SAT16;
      started      <= 1'b0;
    end else begin
      header_pos   <= header_pos_next;
      frame_leds   <= frame_leds_next;
      count_high   <= count_high_next;
      led_pos      <= led_pos_next;
      byte_in_led  <= byte_in_led_next;
      red_hold     <= red_hold_next;
      green_hold   <= green_hold_next;
      idle_elapsed <= idle_elapsed_next;
      ack_elapsed  <= ack_elapsed_next;
      started      <= started_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_res;
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, n_res} - {2'd0, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (n_res == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(lsfp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_non_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != lsfp_pkg::KIND_LED_WRITE)) |->
    (led_index == 10'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0 && white == 8'd0))
    else $error("non-write result carries payload");

  a_header_range: assert property (@(posedge clk) disable iff (rst)
    header_pos <= lsfp_pkg::HDR_DATA)
    else $error("header position out of range");

  a_first_tick: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode && !started) |=> (started && header_pos == lsfp_pkg::HDR_A))
    else $error("first tick did not clear frame");

  a_byte_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !mode) |=> (idle_elapsed == 16'd0))
    else $error("byte transfer did not clear idle counter");
`endif

endmodule
